@@ hw/rtl/mm_pkg.sv @@
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants of the matrix multiplier
// Sizes, configuration register indexes, command and result records.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int DEPTH       = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DIM_W       = $clog2(MAX_DIM + 1);
	localparam int DATA_W      = 32;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 2;

	localparam int CMDQ_DEPTH  = 4;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
	localparam int RESQ_DEPTH  = 8;
	localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

	localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
	} dims_t;

	typedef struct packed {
		logic                     wr_a;
		logic                     wr_b;
		logic                     start;
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     saturated;
		logic                     last_out;
	} res_t;

	// A zero dimension acts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply: dense Q16.16 matrix multiplier
// Input: push/full queue of A and B elements, each row-major, in any mix.
// op selects A (0) or B (1). The element that completes B starts the product.
// Output: empty/pop queue of product elements in row-major order; saturated
// marks a clipped element and last_out marks the final one.
// Configuration: cfg_write with cfg_index 0 (rows of A), 1 (inner dimension)
// and 2 (columns of B); write only while the block is idle.
// Loading takes one element per cycle while full is low. A product runs
// rows * inner * cols multiply-accumulates, one per cycle in the engine while
// the result queue has room; each result passes read, multiply, accumulate.
// During a product, up to four further requests are queued, then full rises.
// Reset clears counters and queues and sets all dimensions to 8; matrix
// contents are undefined until loaded. When the receiver stops popping, the
// engine pauses once eight results are waiting or in flight.
// ----------------------------------------------------------------------------
module matrix_multiply import mm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] element,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] product,
	output logic                     saturated,
	output logic                     last_out
);

	logic  accept;
	logic  cmd_push, cmd_pop, cmd_empty;
	cmd_t  cmd_in, cmd_head;
	dims_t dims;
	logic  res_push, res_pop;
	res_t  res_in, res_head;

	assign accept    = push && !full;
	assign res_pop   = pop && !empty;
	assign product   = res_head.product;
	assign saturated = res_head.saturated;
	assign last_out  = res_head.last_out;

	mm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.op        (op),
		.element   (element),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.dims      (dims)
	);

	mm_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (full),
		.pop       (cmd_pop),
		.head      (cmd_head),
		.empty     (cmd_empty)
	);

	mm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dims      (dims),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_pop   (res_pop),
		.res_push  (res_push),
		.res       (res_in)
	);

	mm_result_queue u_result_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (res_pop),
		.head      (res_head),
		.empty     (empty)
	);

endmodule

@@ hw/rtl/mm_front.sv @@
// ----------------------------------------------------------------------------
// mm_front: configuration registers and element classifier
// Counts incoming A and B elements and turns each request into a store
// command, a start command that may also store the final B, or nothing.
// ----------------------------------------------------------------------------
module mm_front import mm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     accept,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] element,
	output logic                     cmd_push,
	output cmd_t                     cmd,
	output dims_t                    dims
);

	logic [DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic [CNT_W-1:0] size_a, size_b;
	logic [CNT_W:0]   count_b_inc;

	assign size_a      = CNT_W'(rows_q) * CNT_W'(inner_q);
	assign size_b      = CNT_W'(inner_q) * CNT_W'(cols_q);
	assign count_b_inc = {1'b0, count_b_q} + (CNT_W+1)'(1);

	assign dims.rows  = rows_q;
	assign dims.inner = inner_q;
	assign dims.cols  = cols_q;

	always_comb begin
		cmd.wr_a  = 1'b0;
		cmd.wr_b  = 1'b0;
		cmd.start = 1'b0;
		cmd.data  = element;
		if (op == 1'b0) begin
			cmd.addr = count_a_q[ADDR_W-1:0];
			cmd.wr_a = count_a_q < size_a;
		end else begin
			cmd.addr  = count_b_q[ADDR_W-1:0];
			cmd.wr_b  = count_b_q < size_b;
			cmd.start = count_b_inc >= {1'b0, size_b};
		end
		cmd_push = accept && (cmd.wr_a || cmd.wr_b || cmd.start);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= clamp_dim(DIM_RESET);
			inner_q <= clamp_dim(DIM_RESET);
			cols_q  <= clamp_dim(DIM_RESET);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROWS_A:    rows_q  <= clamp_dim(cfg_data);
				REG_INNER_DIM: inner_q <= clamp_dim(cfg_data);
				REG_COLS_B:    cols_q  <= clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
		end else if (accept) begin
			if (cmd.wr_a) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end
			if (op == 1'b1) begin
				if (cmd.start) begin
					count_a_q <= '0;
					count_b_q <= '0;
				end else begin
					count_b_q <= count_b_inc[CNT_W-1:0];
				end
			end
		end
	end

endmodule

@@ hw/rtl/mm_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// mm_cmd_queue: command queue between classifier and engine
// A small register queue; lets loading continue while the engine multiplies.
// ----------------------------------------------------------------------------
module mm_cmd_queue import mm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_push, do_pop;

	assign full    = count_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign empty   = count_q == '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CMDQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CMDQ_CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/mm_back.sv @@
// ----------------------------------------------------------------------------
// mm_back: matrix stores and multiply-accumulate engine
// Executes store commands and, on start, walks every (row, column, term)
// through a read, multiply and accumulate pipeline, then rounds and
// saturates each sum of products.
// ----------------------------------------------------------------------------
module mm_back import mm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  dims_t dims,
	input  cmd_t  cmd,
	input  logic  cmd_empty,
	output logic  cmd_pop,
	input  logic  res_pop,
	output logic  res_push,
	output res_t  res
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                   state_q;
	logic [DATA_W-1:0]        mem_a_q [DEPTH];
	logic [DATA_W-1:0]        mem_b_q [DEPTH];
	logic [DIM_W-1:0]         r_q, c_q, t_q;
	logic [ADDR_W-1:0]        row_base_q, ib_q;
	logic [ADDR_W-1:0]        ia;
	logic [RESQ_CNT_W-1:0]    reserved_q;
	logic                     issue, t_last, c_last, r_last, issue_last;

	logic                     valid_s1, first_s1, lastt_s1, lastout_s1;
	logic signed [DATA_W-1:0] rd_a_s1, rd_b_s1;
	logic                     valid_s2, first_s2, lastt_s2, lastout_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s3, lastout_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-48:0]        acc_top;
	logic                     in_range;

	assign t_last     = t_q == dims.inner - DIM_W'(1);
	assign c_last     = c_q == dims.cols - DIM_W'(1);
	assign r_last     = r_q == dims.rows - DIM_W'(1);
	assign issue      = (state_q == ST_RUN) && (reserved_q < RESQ_CNT_W'(RESQ_DEPTH));
	assign issue_last = issue && t_last;
	assign ia         = ADDR_W'(row_base_q + ADDR_W'(t_q));
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty;

	// Store writes and operand reads; read data is registered.
	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.wr_a) begin
			mem_a_q[cmd.addr] <= cmd.data;
		end
		if (cmd_pop && cmd.wr_b) begin
			mem_b_q[cmd.addr] <= cmd.data;
		end
		rd_a_s1 <= mem_a_q[ia];
		rd_b_s1 <= mem_b_q[ib_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			r_q        <= '0;
			c_q        <= '0;
			t_q        <= '0;
			row_base_q <= '0;
			ib_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.start) begin
						state_q    <= ST_RUN;
						r_q        <= '0;
						c_q        <= '0;
						t_q        <= '0;
						row_base_q <= '0;
						ib_q       <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (t_last) begin
							t_q <= '0;
							if (c_last) begin
								c_q        <= '0;
								ib_q       <= '0;
								row_base_q <= ADDR_W'(row_base_q + ADDR_W'(dims.inner));
								if (r_last) begin
									state_q <= ST_IDLE;
									r_q     <= '0;
								end else begin
									r_q <= r_q + DIM_W'(1);
								end
							end else begin
								c_q  <= c_q + DIM_W'(1);
								ib_q <= ADDR_W'(c_q + DIM_W'(1));
							end
						end else begin
							t_q  <= t_q + DIM_W'(1);
							ib_q <= ADDR_W'(ib_q + ADDR_W'(dims.cols));
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Results in flight or waiting in the result queue; issue stops when the
	// queue could not take another one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (issue_last && !res_pop) begin
			reserved_q <= reserved_q + RESQ_CNT_W'(1);
		end else if (res_pop && !issue_last) begin
			reserved_q <= reserved_q - RESQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && lastt_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1   <= t_q == '0;
		lastt_s1   <= t_last;
		lastout_s1 <= t_last && c_last && r_last;
		first_s2   <= first_s1;
		lastt_s2   <= lastt_s1;
		lastout_s2 <= lastout_s1;
		prod_s2    <= PROD_W'(rd_a_s1) * PROD_W'(rd_b_s1);
		lastout_s3 <= lastout_s2;
		// The rounding half is folded into the start of every sum.
		if (valid_s2) begin
			acc_q <= (first_s2 ? ACC_W'(1 << 15) : acc_q) + ACC_W'(prod_s2);
		end
	end

	assign acc_top  = acc_q[ACC_W-1:47];
	assign in_range = (acc_top == '0) || (acc_top == '1);

	always_comb begin
		res_push      = valid_s3;
		res.saturated = !in_range;
		res.last_out  = lastout_s3;
		if (in_range) begin
			res.product = acc_q[47:16];
		end else if (acc_q[ACC_W-1]) begin
			res.product = SAT_NEG;
		end else begin
			res.product = SAT_POS;
		end
	end

endmodule

@@ hw/rtl/mm_result_queue.sv @@
// ----------------------------------------------------------------------------
// mm_result_queue: output queue of product elements
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module mm_result_queue import mm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	input  logic pop,
	output res_t head,
	output logic empty
);

	res_t                  entry_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RESQ_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign empty  = count_q == '0;
	assign head   = entry_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	// The engine only issues work it has room for, so push never overflows.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + RESQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RESQ_PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + RESQ_CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - RESQ_CNT_W'(1);
			end
		end
	end

endmodule

@@ dv/mm_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_tb_pkg: verification constants for the matrix multiplier
// Element kind codes and the undecoded register index, shared by the
// stimulus and the checker.
// ----------------------------------------------------------------------------
package mm_tb_pkg;
	import mm_pkg::*;

	localparam logic OP_ELEM_A = 1'b0;
	localparam logic OP_ELEM_B = 1'b1;

	// The one index that the block decodes to no register.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

endpackage

@@ dv/mm_product_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_product_checker: scoreboard for the matrix multiplier
// Watches the register port and both queues, keeps its own copy of the
// matrix stores and dimensions, and predicts every product element in
// order. Each popped result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mm_product_checker import mm_pkg::*, mm_tb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     push,
	input  logic                     full,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] element,
	input  logic                     empty,
	input  logic                     pop,
	input  logic signed [DATA_W-1:0] product,
	input  logic                     saturated,
	input  logic                     last_out,
	output int                       mismatches,
	output int                       outstanding,
	output int                       compared,
	output int                       clipped
);

	localparam int SUM_W = 72;
	localparam int FRAC  = 16;

	logic signed [DATA_W-1:0] a_words [DEPTH];
	logic signed [DATA_W-1:0] b_words [DEPTH];
	int                       a_count;
	int                       b_count;
	int                       n_rows;
	int                       n_inner;
	int                       n_cols;
	res_t                     expected_products [$];
	res_t                     want;

	function automatic int fit_dim(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// Exact sum of products, rounded half up to Q16.16 and clipped.
	function automatic res_t dot_entry(input int row, input int col);
		logic signed [SUM_W-1:0] acc;
		res_t                    res;
		int                      t;
		acc = '0;
		for (t = 0; t < n_inner; t++) begin
			acc = acc + a_words[(row * n_inner + t) % DEPTH]
				* b_words[(t * n_cols + col) % DEPTH];
		end
		acc = acc + (SUM_W'(1) <<< (FRAC - 1));
		// In range when every bit above the result's sign bit copies it.
		if (&acc[SUM_W-1:DATA_W+FRAC-1] || ~|acc[SUM_W-1:DATA_W+FRAC-1]) begin
			res.product   = acc[DATA_W+FRAC-1:FRAC];
			res.saturated = 1'b0;
		end else begin
			res.product   = acc[SUM_W-1] ? SAT_NEG : SAT_POS;
			res.saturated = 1'b1;
		end
		res.last_out = 1'b0;
		return res;
	endfunction

	task automatic take_element(input logic kind, input logic signed [DATA_W-1:0] value);
		int   size_a;
		int   size_b;
		int   row;
		int   col;
		res_t res;
		size_a = n_rows * n_inner;
		size_b = n_inner * n_cols;
		if (kind == OP_ELEM_A) begin
			if (a_count < size_a) begin
				a_words[a_count % DEPTH] = value;
				a_count++;
			end
		end else begin
			// After a resize B may already be full; the element then only starts the product.
			if (b_count < size_b) begin
				b_words[b_count % DEPTH] = value;
			end
			if (b_count + 1 < size_b) begin
				b_count++;
			end else begin
				for (row = 0; row < n_rows; row++) begin
					for (col = 0; col < n_cols; col++) begin
						res = dot_entry(row, col);
						res.last_out = (row == n_rows - 1) && (col == n_cols - 1);
						expected_products.push_back(res);
					end
				end
				a_count = 0;
				b_count = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count = 0;
			b_count = 0;
			n_rows  = int'(DIM_RESET);
			n_inner = int'(DIM_RESET);
			n_cols  = int'(DIM_RESET);
			expected_products.delete();
			mismatches  = 0;
			outstanding = 0;
			compared    = 0;
			clipped     = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_products.size() == 0) begin
					$error("product result %h with no prediction waiting", product);
					mismatches++;
				end else begin
					want = expected_products.pop_front();
					if (product !== want.product) begin
						$error("product: expected %h, actual %h", want.product, product);
						mismatches++;
					end
					if (saturated !== want.saturated) begin
						$error("saturated: expected %b, actual %b", want.saturated, saturated);
						mismatches++;
					end
					if (last_out !== want.last_out) begin
						$error("last_out: expected %b, actual %b", want.last_out, last_out);
						mismatches++;
					end
					compared++;
					if (want.saturated) begin
						clipped++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_ROWS_A: begin
						n_rows = fit_dim(cfg_data);
					end
					REG_INNER_DIM: begin
						n_inner = fit_dim(cfg_data);
					end
					REG_COLS_B: begin
						n_cols = fit_dim(cfg_data);
					end
					default: begin
					end
				endcase
			end
			if (push && !full) begin
				take_element(op, element);
			end
			outstanding = expected_products.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the matrix multiplier
// Drives directed and random matrix loads over a range of dimension settings
// with random gaps on both queues, a long result-side stall and idle pauses.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
	import mm_pkg::*;
	import mm_tb_pkg::*;

	localparam int SETTLE_CYCLES  = 20;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 3000;
	localparam int ITEM_GOAL      = 180;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data  = '0;
	logic                     push      = 1'b0;
	logic                     op        = OP_ELEM_A;
	logic signed [DATA_W-1:0] element   = '0;
	logic                     pop       = 1'b0;
	logic                     full;
	logic                     empty;
	logic signed [DATA_W-1:0] product;
	logic                     saturated;
	logic                     last_out;

	int mismatches;
	int outstanding;
	int compared;
	int clipped;
	int requests_sent = 0;
	int surplus_sent  = 0;
	int dim_sets      = 0;
	int quiet_cycles  = 0;
	int tx_gap_max    = 3;
	int rx_gap_max    = 3;
	bit hold_rx       = 1'b0;

	matrix_multiply u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.op        (op),
		.element   (element),
		.empty     (empty),
		.pop       (pop),
		.product   (product),
		.saturated (saturated),
		.last_out  (last_out)
	);

	mm_product_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.op          (op),
		.element     (element),
		.empty       (empty),
		.pop         (pop),
		.product     (product),
		.saturated   (saturated),
		.last_out    (last_out),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.clipped     (clipped)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Timeout: no request accepted for %0d cycles.", STALL_LIMIT);
		$display("matrix_multiply verification failed");
		$finish;
	end

	// Mostly small values, some near the clipping boundary, some full range.
	function automatic logic signed [DATA_W-1:0] draw_element();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $signed($urandom) >>> 8;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7FFF_FFFF;
					1: v = 32'sh8000_0000;
					2: v = '0;
					default: v = -32'sd1;
				endcase
			end
			default: begin
				v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			end
		endcase
		return v;
	endfunction

	// Called and returns at a falling edge; push stays high for a following request.
	task automatic send(input logic kind, input logic signed [DATA_W-1:0] value);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push    <= 1'b1;
		op      <= kind;
		element <= value;
		do @(posedge clk); while (full);
		@(negedge clk);
		requests_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every predicted product has been popped and the request queue has drained.
	task automatic drain();
		push <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_dims(input int rows, input int inner, input int cols);
		drain();
		write_reg(REG_ROWS_A, CFG_W'(rows));
		write_reg(REG_INNER_DIM, CFG_W'(inner));
		write_reg(REG_COLS_B, CFG_W'(cols));
		dim_sets++;
	endtask

	// A and B elements interleave at random; the final B always comes after all of A.
	task automatic load_matrices(input int rows, input int inner, input int cols);
		int size_a;
		int size_b;
		int na;
		int nb;
		size_a = rows * inner;
		size_b = inner * cols;
		na = 0;
		nb = 0;
		while (na < size_a || nb < size_b) begin
			if (na == size_a && nb < size_b - 1 && $urandom_range(0, 7) == 0) begin
				send(OP_ELEM_A, draw_element());
				surplus_sent++;
			end else if (na < size_a && (nb == size_b - 1 || $urandom_range(0, 1) == 0)) begin
				send(OP_ELEM_A, draw_element());
				na++;
			end else begin
				send(OP_ELEM_B, draw_element());
				nb++;
			end
		end
	endtask

	initial begin
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, rx_gap_max);
			if (hold_rx) begin
				hold_rx = 1'b0;
				gap = RX_HOLD_CYCLES;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin
		int r;
		int i;
		int c;
		int loads;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Two by two outer product of the extreme values, with a surplus A request.
		write_reg(REG_ROWS_A, 4'd2);
		write_reg(REG_INNER_DIM, 4'd1);
		write_reg(REG_COLS_B, 4'd2);
		dim_sets++;
		send(OP_ELEM_A, 32'sh7FFF_FFFF);
		send(OP_ELEM_A, 32'sh8000_0000);
		send(OP_ELEM_B, 32'sh7FFF_FFFF);
		send(OP_ELEM_A, 32'sh0001_0000);
		surplus_sent++;
		send(OP_ELEM_B, 32'sh8000_0000);

		// Out-of-range dimensions clamp to eight rows and one inner element.
		drain();
		write_reg(REG_ROWS_A, 4'd15);
		write_reg(REG_INNER_DIM, 4'd0);
		write_reg(REG_COLS_B, 4'd1);
		write_reg(REG_UNUSED, 4'd4);
		dim_sets++;
		send(OP_ELEM_A, 32'sh0000_0000);
		send(OP_ELEM_A, -32'sd1);
		send(OP_ELEM_A, 32'sh0001_0000);
		send(OP_ELEM_A, 32'shFFFF_0000);
		send(OP_ELEM_A, 32'sh0000_8000);
		send(OP_ELEM_A, 32'sh7FFF_FFFF);
		send(OP_ELEM_A, 32'sh8000_0000);
		send(OP_ELEM_A, 32'sh1234_5678);
		send(OP_ELEM_B, 32'shFFFF_8000);

		// Shrink the inner dimension while loading, so B is already complete.
		set_dims(2, 2, 2);
		repeat (4) send(OP_ELEM_A, draw_element());
		repeat (2) send(OP_ELEM_B, draw_element());
		drain();
		write_reg(REG_INNER_DIM, 4'd1);
		send(OP_ELEM_B, draw_element());

		// The receiver stalls during the wide product so both queues fill up.
		set_dims(8, 1, 8);
		hold_rx = 1'b1;
		repeat (2) load_matrices(8, 1, 8);
		set_dims(1, 1, 1);
		repeat (4) load_matrices(1, 1, 1);
		set_dims(1, 8, 1);
		repeat (2) load_matrices(1, 8, 1);

		while (requests_sent - surplus_sent < ITEM_GOAL) begin
			r = $urandom_range(1, 4);
			i = $urandom_range(1, 4);
			c = $urandom_range(1, 4);
			set_dims(r, i, c);
			loads = $urandom_range(1, 3);
			repeat (loads) begin
				tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
				rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
				load_matrices(r, i, c);
				if ($urandom_range(0, 3) == 0) begin
					drain();
				end
			end
		end
		tx_gap_max = 3;
		rx_gap_max = 3;
		drain();

		$display("Sent %0d element requests (%0d surplus) over %0d dimension settings.",
			requests_sent, surplus_sent, dim_sets);
		$display("Compared %0d product elements, %0d of them clipped.", compared, clipped);
		if (mismatches == 0 && outstanding == 0) begin
			$display("matrix_multiply verification clean");
		end else begin
			$display("matrix_multiply verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mm_pkg.sv
hw/rtl/mm_front.sv
hw/rtl/mm_cmd_queue.sv
hw/rtl/mm_back.sv
hw/rtl/mm_result_queue.sv
hw/rtl/matrix_multiply.sv
dv/mm_tb_pkg.sv
dv/mm_product_checker.sv
dv/testbench.sv
